// ===== rtl/core/pil_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types and constants for the positional insert/erase list.
// ----------------------------------------------------------------------------

package pil_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned IDX_W  = 11;

	typedef enum logic [2:0] {
		MODE_APPEND = 3'd0,
		MODE_POP    = 3'd1,
		MODE_INSERT = 3'd2,
		MODE_ERASE  = 3'd3,
		MODE_READ   = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_SHIFT_UP   = 2'd2,
		CELL_SHIFT_DOWN = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [IDX_W-1:0]    tgt;
		logic [DATA_W-1:0]   value;
	} cell_cmd_t;

	typedef struct packed {
		status_t             status;
		logic [CNT_W-1:0]    count;
		logic                is_empty;
		logic                rd_en;
	} ctrl_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/pil_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pil_req_if
// Request channel: one list operation per word.
// ----------------------------------------------------------------------------

interface pil_req_if;

	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [4:0]         position;
	logic signed [31:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/pil_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pil_rsp_if
// Response channel: one result word per operation.
// ----------------------------------------------------------------------------

interface pil_rsp_if;

	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [4:0]         count;
	logic               is_empty;
	logic [1:0]         status;

	modport source (output valid, output read_value, output count, output is_empty,
		output status, input ready);
	modport sink   (input valid, input read_value, input count, input is_empty,
		input status, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/positional_insert_erase_list_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_erase_list_top
// Fixed-capacity ordered list of signed words held in a row of cells.
// Result word is registered in the cycle after the request is taken.
// Throughput: one request per cycle unless a pending result stalls on rsp.ready; cells shift or load in the same edge.
// The output register frees req.ready whenever the pending result is taken.
// Reset: arst_n clears the entry count and the output valid; entries are not cleared.
// ----------------------------------------------------------------------------

module positional_insert_erase_list_top #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pil_req_if.sink   req,
	pil_rsp_if.source rsp
);
	import pil_pkg::*;

	localparam int unsigned RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

	logic              accept;
	cell_cmd_t         cmd;
	ctrl_rsp_t         res;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] rd_data;

	logic              out_vld_q;
	logic [DATA_W-1:0] read_value_q;
	logic [CNT_W-1:0]  count_q;
	logic              is_empty_q;
	status_t           status_q;

	assign req.ready = !out_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	pil_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (req.mode),
		.position (req.position),
		.value    (req.value),
		.cmd      (cmd),
		.rsp      (res)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = cmd.value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		pil_cell #(
			.INDEX(i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (req.position == POS_W'(i)) rd_data = cell_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= res.rd_en ? rd_data : '0;
			count_q      <= res.count;
			is_empty_q   <= res.is_empty;
			status_q     <= res.status;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.read_value = read_value_q;
	assign rsp.count      = count_q;
	assign rsp.is_empty   = is_empty_q;
	assign rsp.status     = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/pil_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pil_cell
// One list entry; loads the new value or takes a neighbour's entry.
// ----------------------------------------------------------------------------

module pil_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic                      clk,
	input  wire pil_pkg::cell_cmd_t        cmd,
	input  wire logic [pil_pkg::DATA_W-1:0] left,
	input  wire logic [pil_pkg::DATA_W-1:0] right,
	output logic      [pil_pkg::DATA_W-1:0] data
);
	import pil_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic              at_tgt;
	logic              above_tgt;

	assign at_tgt    = (cmd.tgt == MY_IDX);
	assign above_tgt = (MY_IDX > cmd.tgt);

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_LOAD: begin
				if (at_tgt) data_q <= cmd.value;
			end
			CELL_SHIFT_UP: begin
				if (at_tgt) data_q <= cmd.value;
				else if (above_tgt) data_q <= left;
			end
			CELL_SHIFT_DOWN: begin
				if (at_tgt || above_tgt) data_q <= right;
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/pil_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pil_ctrl
// Entry count, range and fullness checks, and the command broadcast to the cells.
// ----------------------------------------------------------------------------

module pil_ctrl #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [2:0]                 mode,
	input  wire logic [pil_pkg::POS_W-1:0]  position,
	input  wire logic [pil_pkg::DATA_W-1:0] value,
	output pil_pkg::cell_cmd_t              cmd,
	output pil_pkg::ctrl_rsp_t              rsp
);
	import pil_pkg::*;

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_d;
	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] cnt_d_x;
	logic [CMPW-1:0] pos_x;
	logic            full;
	status_t         status;
	cell_op_t        op;
	logic [IDX_W-1:0] tgt;
	logic            rd_en;

	assign cnt_x   = CMPW'(count_q);
	assign cnt_d_x = CMPW'(count_d);
	assign pos_x   = CMPW'(position);
	assign full    = (count_q == CAP_C);

	always_comb begin
		status  = ST_OK;
		count_d = count_q;
		op      = CELL_HOLD;
		tgt     = IDX_W'(cnt_x);
		rd_en   = 1'b0;
		unique case (mode_t'(mode))
			MODE_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					op      = CELL_LOAD;
					count_d = count_q + CW'(1);
				end
			end
			MODE_POP: begin
				if (count_q == '0) status = ST_RANGE;
				else count_d = count_q - CW'(1);
			end
			MODE_INSERT: begin
				tgt = IDX_W'(pos_x);
				if (pos_x > cnt_x) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					op      = CELL_SHIFT_UP;
					count_d = count_q + CW'(1);
				end
			end
			MODE_ERASE: begin
				tgt = IDX_W'(pos_x);
				if (pos_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					op      = CELL_SHIFT_DOWN;
					count_d = count_q - CW'(1);
				end
			end
			MODE_READ: begin
				if (pos_x >= cnt_x) status = ST_RANGE;
				else rd_en = 1'b1;
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	assign cmd.op    = accept ? op : CELL_HOLD;
	assign cmd.tgt   = tgt;
	assign cmd.value = value;

	assign rsp.status   = status;
	assign rsp.count    = cnt_d_x[CNT_W-1:0];
	assign rsp.is_empty = (count_d == '0);
	assign rsp.rd_en    = rd_en;

endmodule

`default_nettype wire
